// ----- hdl/slc_pkg.sv -----
// Shared types and codes for the sequential list engine.
package slc_pkg;

  // Widest index / count carried on the broadcast bus (store depth up to 1024)
  localparam int PTR_W = 11;

  // Operation codes on func_i
  localparam logic [2:0] FN_PUSH_FRONT = 3'd0;
  localparam logic [2:0] FN_PUSH_BACK  = 3'd1;
  localparam logic [2:0] FN_POP_FRONT  = 3'd2;
  localparam logic [2:0] FN_POP_BACK   = 3'd3;
  localparam logic [2:0] FN_INSERT     = 3'd4;
  localparam logic [2:0] FN_ERASE      = 3'd5;
  localparam logic [2:0] FN_FIND       = 3'd6;

  // Status codes on status_o
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_BADPOS   = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  // Action broadcast to every cell of the chain
  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_OPEN  = 2'd1,
    CELL_CLOSE = 2'd2,
    CELL_FIND  = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e           op;
    logic [PTR_W-1:0]   at;
    logic [PTR_W-1:0]   count;
  } cell_cmd_t;

endpackage

// ----- hdl/slc_cell.sv -----
// One storage cell of the list chain: holds one entry, shifts with its neighbors.
module slc_cell #(
  parameter int WORD_BITS = 32,
  parameter int IDX       = 0
) (
  input  logic                  clk_i,
  input  slc_pkg::cell_cmd_t    cmd_i,
  input  logic [WORD_BITS-1:0]  word_i,
  input  logic [WORD_BITS-1:0]  left_i,
  input  logic [WORD_BITS-1:0]  right_i,
  output logic [WORD_BITS-1:0]  data_o,
  output logic                  match_o
);
  import slc_pkg::*;

  localparam logic [PTR_W-1:0] MY_IDX   = PTR_W'(IDX);
  localparam logic [PTR_W-1:0] NEXT_IDX = PTR_W'(IDX + 1);

  logic [WORD_BITS-1:0] entry_q, entry_d;
  logic                 match_q, match_d;

  // next entry: load, take from lower neighbor, take from upper neighbor, or hold
  always_comb begin
    entry_d = entry_q;
    match_d = match_q;
    unique case (cmd_i.op)
      CELL_OPEN: begin
        if (MY_IDX == cmd_i.at) begin
          entry_d = word_i;
        end else if (MY_IDX > cmd_i.at && MY_IDX <= cmd_i.count) begin
          entry_d = left_i;
        end
      end
      CELL_CLOSE: begin
        if (MY_IDX >= cmd_i.at && NEXT_IDX < cmd_i.count) begin
          entry_d = right_i;
        end
      end
      CELL_FIND: begin
        match_d = (entry_q == word_i) && (MY_IDX < cmd_i.count);
      end
      default: begin
      end
    endcase
  end

  // entry and match flag are payload: no reset
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    match_q <= match_d;
  end

  assign data_o  = entry_q;
  assign match_o = match_q;

endmodule

// ----- hdl/sequential_list_engine.sv -----
// Top level of the sequential list engine: command decode, cell chain, find encoder.
//
//  channel   | signals                                   | direction
//  ----------+-------------------------------------------+----------
//  command   | start, busy (out), func_i, value_i,       | in
//            | position_i                                |
//  result    | done_o, status_o, found_index_o, count_o  | out
//
//  For push, pop front, insert and erase the cells from the target up to the
//  end of the list shift or load in the accept cycle (pop back only lowers the
//  count), and the result word is strobed the next cycle. For find the cells
//  compare and register a match flag, then a priority encoder over the match
//  flags picks the first hit in the search state, while busy is high. Reset
//  clears the count; cell contents are left as is. The result strobe cannot be
//  stalled; a new command may be accepted in the same cycle that a result is shown.
module sequential_list_engine #(
  parameter int DEPTH     = 64,
  parameter int WORD_BITS = 32,
  localparam int IDX_W    = $clog2(DEPTH),
  localparam int CNT_W    = $clog2(DEPTH + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         func_i,
  input  logic signed [31:0] value_i,
  input  logic [6:0]         position_i,
  output logic               done_o,
  output logic [2:0]         status_o,
  output logic [IDX_W-1:0]   found_index_o,
  output logic [CNT_W-1:0]   count_o
);
  import slc_pkg::*;

  localparam logic S_IDLE   = 1'b0;
  localparam logic S_SEARCH = 1'b1;

  logic                 state_q, state_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic                 done_q, done_d;
  logic [2:0]           status_q, status_d;
  logic [IDX_W-1:0]     found_q, found_d;

  logic                 accept;
  logic [WORD_BITS+31:0] word_ext;
  logic [WORD_BITS-1:0] word;
  logic [PTR_W-1:0]     cnt_ext, pos_ext, ins_at;
  logic                 full, empty;
  cell_cmd_t            cmd;

  logic [WORD_BITS-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]     match;
  logic                 any_hit;
  logic [IDX_W-1:0]     hit_idx;

  assign accept = start && (state_q == S_IDLE);
  assign busy   = (state_q == S_SEARCH);

  // stored word is the low WORD_BITS of the unsigned 32-bit pattern
  assign word_ext = {{WORD_BITS{1'b0}}, value_i};
  assign word     = word_ext[WORD_BITS-1:0];

  assign cnt_ext = PTR_W'(count_q);
  assign pos_ext = PTR_W'(position_i);
  assign ins_at  = (pos_ext > cnt_ext) ? cnt_ext : pos_ext;
  assign full    = (count_q == CNT_W'(DEPTH));
  assign empty   = (count_q == '0);

  // command decode
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    done_d    = 1'b0;
    status_d  = status_q;
    found_d   = found_q;
    cmd.op    = CELL_HOLD;
    cmd.at    = '0;
    cmd.count = cnt_ext;
    if (state_q == S_SEARCH) begin
      state_d  = S_IDLE;
      done_d   = 1'b1;
      status_d = any_hit ? ST_OK : ST_NOTFOUND;
      found_d  = any_hit ? hit_idx : '0;
    end else if (accept) begin
      done_d   = 1'b1;
      status_d = ST_OK;
      found_d  = '0;
      unique case (func_i)
        FN_PUSH_FRONT, FN_PUSH_BACK, FN_INSERT: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            cmd.op  = CELL_OPEN;
            count_d = count_q + CNT_W'(1);
            priority if (func_i == FN_PUSH_FRONT) begin
              cmd.at = '0;
            end else if (func_i == FN_PUSH_BACK) begin
              cmd.at = cnt_ext;
            end else begin
              cmd.at = ins_at;
            end
          end
        end
        FN_POP_FRONT: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            cmd.op  = CELL_CLOSE;
            cmd.at  = '0;
            count_d = count_q - CNT_W'(1);
          end
        end
        FN_POP_BACK: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            count_d = count_q - CNT_W'(1);
          end
        end
        FN_ERASE: begin
          if (pos_ext >= cnt_ext) begin
            status_d = ST_BADPOS;
          end else begin
            cmd.op  = CELL_CLOSE;
            cmd.at  = pos_ext;
            count_d = count_q - CNT_W'(1);
          end
        end
        FN_FIND: begin
          cmd.op  = CELL_FIND;
          done_d  = 1'b0;
          state_d = S_SEARCH;
        end
        default: begin
        end
      endcase
    end
  end

  // chain of cells, each linked to its two neighbors
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [WORD_BITS-1:0] left, right;
    if (g == 0) begin : g_first
      assign left = word;
    end else begin : g_mid_l
      assign left = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_data[g+1];
    end
    slc_cell #(
      .WORD_BITS (WORD_BITS),
      .IDX       (g)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .word_i  (word),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[g]),
      .match_o (match[g])
    );
  end

  // first hit among the registered match flags
  always_comb begin
    hit_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = IDX_W'(i);
      end
    end
  end
  assign any_hit = |match;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    found_q  <= found_d;
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign found_index_o = found_q;
  assign count_o       = count_q;

  // checks
  a_no_done_while_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !done_o) else $error("result strobed during search cycle");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH)) else $error("entry count above depth");

  a_find_enters_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && func_i == FN_FIND) |=> (busy && !done_o))
    else $error("find did not enter search cycle");

  a_other_done_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && func_i != FN_FIND) |=> (done_o && !busy))
    else $error("command without result in next cycle");

  a_search_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> (!busy && done_o && $stable(count_o)))
    else $error("search did not finish in one cycle");

endmodule

// ----- tb/sv/list_engine_checker.sv -----
// Result checker for the sequential list engine: predicts each word and compares.
`timescale 1ns / 100ps

module list_engine_checker #(
  parameter int DEPTH    = 64,
  localparam int IDX_W   = $clog2(DEPTH),
  localparam int CNT_W   = $clog2(DEPTH + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic [2:0]         func_i,
  input  logic signed [31:0] value_i,
  input  logic [6:0]         position_i,
  input  logic               done_i,
  input  logic [2:0]         status_i,
  input  logic [IDX_W-1:0]   found_index_i,
  input  logic [CNT_W-1:0]   count_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  import slc_pkg::*;

  typedef struct packed {
    logic [2:0]       status;
    logic [IDX_W-1:0] found;
    logic [CNT_W-1:0] count;
  } list_result_t;

  // Shadow copy of the list and its length
  logic signed [31:0] list_mem [DEPTH];
  int                 list_len;
  list_result_t       result_wait_q [$];
  int                 mismatch_cnt;

  assign fail_count_o = mismatch_cnt;
  assign pending_o    = result_wait_q.size();

  initial begin
    list_len     = 0;
    mismatch_cnt = 0;
  end

  // Apply one command word to the shadow list, return what the block must report
  task automatic apply_list_op(input logic [2:0] f, input logic signed [31:0] v,
                               input logic [6:0] p, output list_result_t r);
    int at;
    int k;
    r.status = ST_OK;
    r.found  = '0;
    case (f)
      FN_PUSH_FRONT, FN_PUSH_BACK, FN_INSERT: begin
        if (list_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          if (f == FN_PUSH_FRONT) at = 0;
          else if (f == FN_PUSH_BACK) at = list_len;
          else at = (int'(p) > list_len) ? list_len : int'(p);
          for (k = list_len; k > at; k--) list_mem[k] = list_mem[k-1];
          list_mem[at] = v;
          list_len++;
        end
      end
      FN_POP_FRONT: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          for (k = 0; k + 1 < list_len; k++) list_mem[k] = list_mem[k+1];
          list_len--;
        end
      end
      FN_POP_BACK: begin
        if (list_len == 0) r.status = ST_EMPTY;
        else list_len--;
      end
      FN_ERASE: begin
        if (int'(p) >= list_len) begin
          r.status = ST_BADPOS;
        end else begin
          for (k = int'(p); k + 1 < list_len; k++) list_mem[k] = list_mem[k+1];
          list_len--;
        end
      end
      FN_FIND: begin
        // first match wins
        r.status = ST_NOTFOUND;
        for (k = 0; k < list_len; k++) begin
          if (r.status == ST_NOTFOUND && list_mem[k] == v) begin
            r.status = ST_OK;
            r.found  = k[IDX_W-1:0];
          end
        end
      end
      default: ;  // unused code: no change
    endcase
    r.count = list_len[CNT_W-1:0];
  endtask

  // Retire result words, then log newly accepted command words
  always @(posedge clk_i) begin
    list_result_t got;
    list_result_t want;
    if (rst_ni) begin
      if (done_i) begin
        got = '{status: status_i, found: found_index_i, count: count_i};
        if (result_wait_q.size() == 0) begin
          $display("%0t: unexpected result word status=%0d found=%0d count=%0d",
                   $time, got.status, got.found, got.count);
          mismatch_cnt++;
        end else begin
          want = result_wait_q.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            mismatch_cnt++;
          end
          if (got.found !== want.found) begin
            $display("%0t: found_index expected %0d actual %0d",
                     $time, want.found, got.found);
            mismatch_cnt++;
          end
          if (got.count !== want.count) begin
            $display("%0t: count expected %0d actual %0d", $time, want.count, got.count);
            mismatch_cnt++;
          end
        end
      end
      if (start_i && !busy_i) begin
        apply_list_op(func_i, value_i, position_i, want);
        result_wait_q.push_back(want);
      end
    end
  end

endmodule

// ----- tb/sv/tb.sv -----
// Testbench top for the sequential list engine: clock, reset, command stimulus, verdict.
`timescale 1ns / 100ps

module tb;
  import slc_pkg::*;

  localparam int DEPTH     = 64;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int RAND_WORDS = 377;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_e;

  logic               clk_i      = 1'b0;
  logic               rst_ni     = 1'b0;
  logic               start      = 1'b0;
  logic [2:0]         func_i     = FN_PUSH_BACK;
  logic signed [31:0] value_i    = '0;
  logic [6:0]         position_i = '0;
  logic               busy;
  logic               done_o;
  logic [2:0]         status_o;
  logic [IDX_W-1:0]   found_index_o;
  logic [CNT_W-1:0]   count_o;
  int                 fail_count;
  int                 pending;
  bit                 no_idle;

  sequential_list_engine #(.DEPTH(DEPTH), .WORD_BITS(32)) u_top (
    .clk_i, .rst_ni, .start, .busy, .func_i, .value_i, .position_i,
    .done_o, .status_o, .found_index_o, .count_o
  );

  list_engine_checker #(.DEPTH(DEPTH)) u_checker (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .func_i, .value_i, .position_i,
    .done_i(done_o), .status_i(status_o), .found_index_i(found_index_o),
    .count_i(count_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  always #2 clk_i = ~clk_i;

  // Present one command word, hold it until accepted, then maybe idle
  task automatic send_word(input logic [2:0] f, input logic signed [31:0] v,
                           input logic [6:0] p);
    int roll;
    int gap;
    start      <= 1'b1;
    func_i     <= f;
    value_i    <= v;
    position_i <= p;
    do @(posedge clk_i); while (busy);
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 55) gap = 0;
    else if (roll < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(5, 30);
    if (gap > 0) begin
      start <= 1'b0;
      // junk on the payload while idle
      func_i     <= 3'($urandom);
      value_i    <= $urandom;
      position_i <= 7'($urandom);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Values from a small pool so finds hit, plus extremes and full-range noise
  function automatic logic signed [31:0] pick_value();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return $urandom_range(0, 15);
    if (roll < 70) begin
      case ($urandom_range(0, 3))
        0: return 32'sh7FFF_FFFF;
        1: return 32'sh8000_0000;
        2: return -32'sd1;
        default: return 32'sd0;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [6:0] pick_position();
    if ($urandom_range(0, 99) < 65) return 7'($urandom_range(0, DEPTH));
    return 7'($urandom);
  endfunction

  function automatic logic [2:0] pick_func(input phase_e ph);
    int roll;
    roll = $urandom_range(0, 99);
    case (ph)
      PH_FILL: begin
        if (roll < 30) return FN_PUSH_FRONT;
        if (roll < 55) return FN_PUSH_BACK;
        if (roll < 80) return FN_INSERT;
        if (roll < 92) return FN_FIND;
        return 3'($urandom_range(FN_POP_FRONT, FN_ERASE));
      end
      PH_DRAIN: begin
        if (roll < 25) return FN_POP_FRONT;
        if (roll < 50) return FN_POP_BACK;
        if (roll < 75) return FN_ERASE;
        if (roll < 90) return FN_FIND;
        return 3'($urandom_range(FN_PUSH_FRONT, FN_PUSH_BACK));
      end
      default: return 3'($urandom_range(FN_PUSH_FRONT, FN_FIND));
    endcase
  endfunction

  // Stimulus
  initial begin
    int sent;
    int run_len;
    phase_e ph;
    no_idle = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty-list cases first
    send_word(FN_POP_FRONT, 32'sd0, 7'd0);
    send_word(FN_POP_BACK, 32'sd0, 7'd0);
    send_word(FN_ERASE, 32'sd0, 7'd0);
    send_word(FN_FIND, 32'sd0, 7'd0);
    // extremes of the word, insert clamped past the end
    send_word(FN_PUSH_FRONT, 32'sh7FFF_FFFF, 7'd0);
    send_word(FN_PUSH_BACK, 32'sh8000_0000, 7'd127);
    send_word(FN_INSERT, -32'sd1, 7'd127);
    send_word(FN_INSERT, 32'sd5, 7'd0);
    send_word(FN_INSERT, 32'sd5, 7'd2);
    send_word(FN_FIND, 32'sh8000_0000, 7'd0);
    send_word(FN_FIND, 32'sd5, 7'd0);
    send_word(FN_FIND, -32'sd1, 7'd0);
    send_word(FN_FIND, 32'sd1234, 7'd0);
    // erase at the count and far beyond is rejected
    send_word(FN_ERASE, 32'sd0, 7'd5);
    send_word(FN_ERASE, 32'sd0, 7'd127);
    send_word(FN_ERASE, 32'sd0, 7'd4);
    send_word(FN_ERASE, 32'sd0, 7'd0);
    // unused code seven leaves the list alone
    send_word(3'd7, 32'sd9, 7'd1);
    send_word(FN_POP_FRONT, 32'sd0, 7'd0);
    send_word(FN_POP_BACK, 32'sd0, 7'd0);
    send_word(FN_POP_BACK, 32'sd0, 7'd0);
    send_word(FN_POP_BACK, 32'sd0, 7'd0);
    send_word(FN_FIND, 32'sd5, 7'd0);

    // Random: fill, drain and mixed runs picked at random so the list hits full and empty
    sent = 0;
    while (sent < RAND_WORDS) begin
      case ($urandom_range(0, 2))
        0: ph = PH_FILL;
        1: ph = PH_DRAIN;
        default: ph = PH_MIXED;
      endcase
      run_len = (ph == PH_FILL) ? $urandom_range(60, 100) : $urandom_range(20, 70);
      no_idle = ($urandom_range(0, 3) == 0);
      repeat (run_len) begin
        if (sent < RAND_WORDS) begin
          send_word(pick_func(ph), pick_value(), pick_position());
          sent++;
        end
      end
    end
    no_idle = 1'b0;
    start <= 1'b0;

    // Drain outstanding results, then idle before the verdict
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #500us;
    $display("tb failed");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/slc_pkg.sv
hdl/slc_cell.sv
hdl/sequential_list_engine.sv
tb/sv/list_engine_checker.sv
tb/sv/tb.sv
